// ===== sv/sfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants of the switch flick counter.
// ----------------------------------------------------------------------------
package sfc_pkg;

    // lane limit set by the width of pin_levels
    localparam int LANE_LIMIT        = 8;
    localparam int MAX_SWITCHES_DEF  = 8;

    localparam int ACT_W   = 4;
    localparam int GROUP_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int LEVELS_W = 8;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 3;
    localparam int REC_W   = 8;

    localparam logic [ACT_W-1:0]   ACT_RESET   = 4'd8;
    localparam logic [GROUP_W-1:0] GROUP_RESET = 8'd0;

    // record fields: [0] committed, [1] sampled, [3:2] count, [7:4] timer
    localparam logic [1:0] COUNT_SAT     = 2'b11;
    localparam logic [3:0] TIMER_OFF     = 4'b1111;
    localparam logic [3:0] TIMER_CAP     = 4'b1110;
    localparam logic [3:0] TIMER_TIMEOUT = 4'b1001;
    localparam logic [CNT_W-1:0] FLICK_MAX = 3'd7;

    localparam logic [REC_W-1:0] REC_REST_HI = 8'b0000_0011;
    localparam logic [REC_W-1:0] REC_REST_LO = 8'b0000_0000;
    localparam logic [REC_W-1:0] REC_QUICK   = 8'b0001_0010;
    localparam logic [REC_W-1:0] REC_OFF_HI  = 8'hf3;
    localparam logic [REC_W-1:0] REC_OFF_LO  = 8'hf0;

    typedef enum logic
    {
        FUNC_SCAN = 1'b0,
        FUNC_INIT = 1'b1
    } sfc_func_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_ACTIVE_SWITCHES = 1'b0,
        CFG_GROUP_OFFSET    = 1'b1
    } sfc_cfg_idx_t;

    // event found by one lane on a scan
    typedef struct packed
    {
        logic             emit;
        logic [CNT_W-1:0] cnt;
        logic             lvl;
    } sfc_evt_t;

endpackage

// ===== sv/sfc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc interfaces
// Scan item, event item and configuration write channels.
// ----------------------------------------------------------------------------
interface sfc_scan_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] pin_levels;

    modport source (output valid, output func, output pin_levels, input ready);
    modport sink   (input valid, input func, input pin_levels, output ready);
endinterface

interface sfc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] switch_index;
    logic [2:0] flick_count;
    logic       level;
    logic [7:0] group_base;
    logic       last;

    modport source (output valid, output switch_index, output flick_count,
                    output level, output group_base, output last, input ready);
    modport sink   (input valid, input switch_index, input flick_count,
                    input level, input group_base, input last, output ready);
endinterface

interface sfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/sfc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_lane
// One switch lane: holds the switch record and evaluates it on each item.
// ----------------------------------------------------------------------------
module sfc_lane
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              lane_en,
    input  logic              func,
    input  logic              pin,
    output sfc_pkg::sfc_evt_t evt
);
    import sfc_pkg::*;

    logic [REC_W-1:0] rec_reg;
    logic [REC_W-1:0] rec_next;
    logic [REC_W-1:0] folded;
    logic [REC_W-1:0] scan_rec;
    logic [CNT_W-1:0] flicks;
    logic [3:0]       timer;
    logic             samp;

    // fold the new sample into the record
    always_comb
    begin
        folded = rec_reg;
        if (pin != rec_reg[1])
        begin
            if ((rec_reg[0] ^ rec_reg[1]) && (rec_reg[3:2] != COUNT_SAT))
            begin
                folded[3:2] = rec_reg[3:2] + 2'd1;
            end
            folded[1] = ~rec_reg[1];
        end
    end

    // evaluate the folded record
    always_comb
    begin
        samp     = folded[1];
        flicks   = {folded[3:2], folded[0] ^ folded[1]};
        timer    = folded[7:4];
        scan_rec = folded;
        evt      = '0;
        if ((flicks == '0) && ((timer == 4'd0) || (timer == TIMER_OFF)))
        begin
            scan_rec = folded;
        end
        else if (timer == TIMER_OFF)
        begin
            evt      = '{emit: 1'b1, cnt: 3'd1, lvl: 1'b1};
            scan_rec = samp ? REC_OFF_HI : REC_OFF_LO;
        end
        else if ((flicks == 3'd1) && (timer == 4'd0) && samp)
        begin
            evt      = '{emit: 1'b1, cnt: 3'd0, lvl: 1'b1};
            scan_rec = REC_QUICK;
        end
        else if ((flicks >= FLICK_MAX) || (timer >= TIMER_TIMEOUT))
        begin
            evt      = '{emit: 1'b1, cnt: flicks, lvl: samp};
            scan_rec = samp ? REC_REST_HI : REC_REST_LO;
        end
        else
        begin
            scan_rec = {(timer < TIMER_CAP) ? timer + 4'd1 : timer, folded[3:0]};
        end
        if (!lane_en || (func != FUNC_SCAN))
        begin
            evt = '0;
        end
    end

    // record update
    always_comb
    begin
        rec_next = rec_reg;
        if (load && lane_en)
        begin
            unique case (sfc_func_t'(func))
                FUNC_INIT: rec_next = pin ? REC_REST_HI : REC_REST_LO;
                FUNC_SCAN: rec_next = scan_rec;
                default:   rec_next = rec_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

// ===== sv/sfc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_merge
// Collects the lane events of one scan and sends them out one item per cycle
// while the receiver is ready, in lane order, flagging the final one.
// ----------------------------------------------------------------------------
module sfc_merge
#(
    parameter int LANES = sfc_pkg::MAX_SWITCHES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  sfc_pkg::sfc_evt_t            lane_evt [LANES],
    input  logic [sfc_pkg::GROUP_W-1:0]  group_offset,
    output logic                         idle,
    sfc_event_if.source                  event_out
);
    import sfc_pkg::*;

    localparam int SEL_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [LANES-1:0] pend_reg;
    logic [LANES-1:0] pend_next;
    logic [CNT_W-1:0] cnt_reg [LANES];
    logic [LANES-1:0] lvl_reg;
    logic [LANES-1:0] pick;
    logic [SEL_W-1:0] pick_idx;
    logic             pop;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_lvl_reg;
    logic [GROUP_W-1:0] out_group_reg;
    logic               out_last_reg;

    assign idle = (pend_reg == '0);

    // lowest pending lane goes first
    always_comb
    begin
        pick     = '0;
        pick_idx = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pick     = '0;
                pick[i]  = 1'b1;
                pick_idx = SEL_W'(i);
            end
        end
    end

    assign pop = (pend_reg != '0) && (!out_valid_reg || event_out.ready);

    // pending mask
    always_comb
    begin
        pend_next = pend_reg;
        if (load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pend_next[i] = lane_evt[i].emit;
            end
        end
        else if (pop)
        begin
            pend_next = pend_reg & ~pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // per-lane event payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                cnt_reg[i] <= lane_evt[i].cnt;
                lvl_reg[i] <= lane_evt[i].lvl;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (event_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_idx_reg   <= IDX_W'(pick_idx);
            out_cnt_reg   <= cnt_reg[pick_idx];
            out_lvl_reg   <= lvl_reg[pick_idx];
            out_group_reg <= group_offset;
            out_last_reg  <= ((pend_reg & ~pick) == '0);
        end
    end

    assign event_out.valid        = out_valid_reg;
    assign event_out.switch_index = out_idx_reg;
    assign event_out.flick_count  = out_cnt_reg;
    assign event_out.level        = out_lvl_reg;
    assign event_out.group_base   = out_group_reg;
    assign event_out.last         = out_last_reg;

    // selection picks at most one lane
    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pick))
        else $error("merge picked more than one lane");

    // a new scan is never loaded over pending events
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (pend_reg == '0))
        else $error("scan loaded while events pending");

    // each pop retires exactly one pending event
    a_pop_retire: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> ($countones(pend_reg) + 1 == $countones($past(pend_reg))))
        else $error("pop did not retire exactly one event");

endmodule

// ===== sv/switch_flick_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_flick_counter_core
// Wall-switch flick counter: per-lane records, events merged in lane order.
// ----------------------------------------------------------------------------
// All active lanes evaluate a scan item together in the cycle it is accepted.
// The resulting events then leave through a single output register, one
// per cycle while the receiver is ready, lowest lane first, with last set
// on the final one. A scan that causes no event, or an initialize item, does
// not hold off the next item; a scan that causes events holds it off until
// the merge stage has passed every event to its one output port. The
// last event may still wait at the output while the next item is taken.
// Configuration writes are always accepted and take effect the next cycle.
// ----------------------------------------------------------------------------
module switch_flick_counter_core
#(
    parameter int MAX_SWITCHES = sfc_pkg::MAX_SWITCHES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sfc_scan_if.sink    scan_in,
    sfc_event_if.source event_out,
    sfc_cfg_if.sink     cfg
);
    import sfc_pkg::*;

    localparam int LANES = (MAX_SWITCHES < LANE_LIMIT) ? MAX_SWITCHES : LANE_LIMIT;

    logic [ACT_W-1:0]   active_switches_reg;
    logic [GROUP_W-1:0] group_offset_reg;
    logic               load;
    logic               idle;
    sfc_evt_t           lane_evt [LANES];

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_switches_reg <= ACT_RESET;
            group_offset_reg    <= GROUP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (sfc_cfg_idx_t'(cfg.index))
                CFG_ACTIVE_SWITCHES: active_switches_reg <= cfg.wdata[ACT_W-1:0];
                CFG_GROUP_OFFSET:    group_offset_reg    <= cfg.wdata[GROUP_W-1:0];
                default:             group_offset_reg    <= group_offset_reg;
            endcase
        end
    end

    // input handshake
    assign scan_in.ready = idle;
    assign load          = scan_in.valid && idle;

    // switch lanes
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        sfc_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (load),
            .lane_en (ACT_W'(g) < active_switches_reg),
            .func    (scan_in.func),
            .pin     (scan_in.pin_levels[g]),
            .evt     (lane_evt[g])
        );
    end

    // event merge
    sfc_merge #(.LANES(LANES)) u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load && (scan_in.func == FUNC_SCAN)),
        .lane_evt     (lane_evt),
        .group_offset (group_offset_reg),
        .idle         (idle),
        .event_out    (event_out)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the switch flick counter core. Scan and initialize
// items go in through the scan channel. A local copy of the per-lane records
// predicts every event, and each event taken from the output channel is
// checked against the oldest prediction. Directed cases come first. Random
// flick bursts and hold periods follow, under several lane counts and group
// offsets, with the sender and the receiver stalling at random in some phases.
// ----------------------------------------------------------------------------
module testbench;
    import sfc_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SHOW_LIMIT    = 10;
    localparam int RANDOM_ITEMS  = 470;
    localparam int PHASES        = 9;

    typedef struct packed
    {
        logic [IDX_W-1:0]   lane;
        logic [CNT_W-1:0]   count;
        logic               lvl;
        logic [GROUP_W-1:0] grp;
        logic               last;
    } flick_event_t;

    logic clk;
    logic rst_n;

    sfc_scan_if  scan_bus();
    sfc_event_if event_bus();
    sfc_cfg_if   cfg_bus();

    switch_flick_counter_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_in   (scan_bus),
        .event_out (event_bus),
        .cfg       (cfg_bus)
    );

    // local copy of the block state and its registers
    logic [REC_W-1:0]    lane_rec [LANE_LIMIT];
    logic [ACT_W-1:0]    active_cfg;
    logic [GROUP_W-1:0]  group_cfg;
    logic [LEVELS_W-1:0] cur_levels;
    flick_event_t        pending_events [$];

    int mismatches;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // receiver stalls
    initial
    begin
        event_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            event_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // expected events of one accepted item, records updated in place
    function automatic void update_flick_records(sfc_func_t f, logic [LEVELS_W-1:0] lv);
        int                 n;
        int                 base;
        logic               emit;
        flick_event_t       ev;
        logic [REC_W-1:0]   r;
        logic [CNT_W-1:0]   flicks;
        logic [3:0]         tmr;
        logic               pin;
        n = (active_cfg > LANE_LIMIT) ? LANE_LIMIT : int'(active_cfg);
        base = pending_events.size();

        // initialize: load active lanes from the levels
        if (f == FUNC_INIT)
        begin
            for (int i = 0; i < n; i++)
                lane_rec[i] = lv[i] ? REC_REST_HI : REC_REST_LO;
            return;
        end

        // fold in the new samples, counting flips
        for (int i = 0; i < n; i++)
        begin
            r = lane_rec[i];
            if (lv[i] != r[1])
            begin
                if (r[0] != r[1] && r[3:2] != COUNT_SAT)
                    r[3:2] = r[3:2] + 2'd1;
                r[1] = ~r[1];
            end
            lane_rec[i] = r;
        end

        // evaluate each lane in order
        for (int i = 0; i < n; i++)
        begin
            r      = lane_rec[i];
            pin    = r[1];
            flicks = {r[3:2], r[0] ^ r[1]};
            tmr    = r[7:4];
            emit   = 1'b0;
            ev     = '0;
            if (flicks == '0 && (tmr == 4'd0 || tmr == TIMER_OFF))
                continue;
            if (tmr == TIMER_OFF)
            begin
                emit     = 1'b1;
                ev.count = CNT_W'(1);
                ev.lvl   = 1'b1;
                lane_rec[i] = pin ? REC_OFF_HI : REC_OFF_LO;
            end
            else if (flicks == CNT_W'(1) && tmr == 4'd0 && pin)
            begin
                emit     = 1'b1;
                ev.count = '0;
                ev.lvl   = 1'b1;
                lane_rec[i] = REC_QUICK;
            end
            else if (flicks >= FLICK_MAX || tmr >= TIMER_TIMEOUT)
            begin
                emit     = 1'b1;
                ev.count = flicks;
                ev.lvl   = pin;
                lane_rec[i] = pin ? REC_REST_HI : REC_REST_LO;
            end
            else
            begin
                if (tmr < TIMER_CAP)
                    tmr = tmr + 4'd1;
                lane_rec[i] = {tmr, r[3:0]};
            end
            if (emit)
            begin
                ev.lane = IDX_W'(i);
                ev.grp  = group_cfg;
                pending_events.push_back(ev);
            end
        end

        // mark the final event of this scan
        if (pending_events.size() > base)
        begin
            ev = pending_events.pop_back();
            ev.last = 1'b1;
            pending_events.push_back(ev);
        end
    endfunction

    // event checker
    always @(posedge clk)
    begin
        flick_event_t seen;
        flick_event_t want;
        if (rst_n && event_bus.valid && event_bus.ready)
        begin
            seen.lane  = event_bus.switch_index;
            seen.count = event_bus.flick_count;
            seen.lvl   = event_bus.level;
            seen.grp   = event_bus.group_base;
            seen.last  = event_bus.last;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected event: lane %0d count %0d level %0b group %0d last %0b",
                             seen.lane, seen.count, seen.lvl, seen.grp, seen.last);
            end
            else
            begin
                want = pending_events.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"event mismatch: expected lane %0d count %0d level %0b ",
                                  "group %0d last %0b, got lane %0d count %0d level %0b ",
                                  "group %0d last %0b"},
                                 want.lane, want.count, want.lvl, want.grp, want.last,
                                 seen.lane, seen.count, seen.lvl, seen.grp, seen.last);
                end
            end
        end
    end

    // send one item and predict its events on acceptance
    task automatic send_item(sfc_func_t f, logic [LEVELS_W-1:0] lv);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            scan_bus.valid <= 1'b0;
            @(negedge clk);
        end
        scan_bus.valid      <= 1'b1;
        scan_bus.func       <= f;
        scan_bus.pin_levels <= lv;
        @(posedge clk);
        while (!scan_bus.ready)
            @(posedge clk);
        update_flick_records(f, lv);
    endtask

    // stop sending and wait until the block has gone quiet
    task automatic drain_events();
        @(negedge clk);
        scan_bus.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(sfc_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.wdata <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        if (idx == CFG_ACTIVE_SWITCHES)
            active_cfg = data[ACT_W-1:0];
        else
            group_cfg = data;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // both registers, written with the block idle
    task automatic apply_config(logic [ACT_W-1:0] lanes, logic [GROUP_W-1:0] grp);
        logic [CFG_DATA_W-ACT_W-1:0] filler;
        filler = (CFG_DATA_W-ACT_W)'($urandom);
        drain_events();
        write_reg(CFG_ACTIVE_SWITCHES, {filler, lanes});
        write_reg(CFG_GROUP_OFFSET, grp);
    endtask

    // all lanes switch on from rest at once
    task automatic test_quick_on();
        send_item(FUNC_SCAN, 8'h00);
        send_item(FUNC_SCAN, 8'hFF);
    endtask

    // fast toggling until seven changes are counted
    task automatic test_fast_flicks();
        repeat (3)
        begin
            send_item(FUNC_SCAN, 8'h00);
            send_item(FUNC_SCAN, 8'hFF);
        end
    endtask

    // a single switch-off left alone until the timer runs out
    task automatic test_timeout();
        apply_config(4'd8, 8'hFF);
        repeat (10) send_item(FUNC_SCAN, 8'h00);
    endtask

    // no lanes, a few lanes, and a count above the lane limit
    task automatic test_lane_count();
        apply_config(4'd0, 8'h00);
        send_item(FUNC_SCAN, 8'hFF);
        apply_config(4'd3, 8'h5A);
        send_item(FUNC_INIT, 8'hFF);
        send_item(FUNC_SCAN, 8'hAA);
        apply_config(4'd15, 8'h00);
        send_item(FUNC_SCAN, 8'hF8);
    endtask

    // flick bursts, hold periods, initialize items and noise
    task automatic run_flick_traffic(int count);
        int                  sent;
        int                  pick;
        int                  burst;
        int                  hold;
        logic [LEVELS_W-1:0] toggles;
        logic [LEVELS_W-1:0] noise;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                cur_levels = LEVELS_W'($urandom);
                send_item(FUNC_INIT, cur_levels);
                sent++;
            end
            else if (pick < 20)
            begin
                cur_levels = LEVELS_W'($urandom);
                send_item(FUNC_SCAN, cur_levels);
                sent++;
            end
            else
            begin
                toggles = LEVELS_W'($urandom);
                burst   = $urandom_range(1, 8);
                hold    = $urandom_range(0, 11);
                repeat (burst)
                begin
                    noise = ($urandom_range(3) != 0) ? 8'hFF : LEVELS_W'($urandom);
                    cur_levels = cur_levels ^ (toggles & noise);
                    send_item(FUNC_SCAN, cur_levels);
                    sent++;
                end
                repeat (hold)
                begin
                    send_item(FUNC_SCAN, cur_levels);
                    sent++;
                end
            end
        end
    endtask

    // random traffic over the stall modes and several settings
    task automatic test_random_traffic();
        int               mode_send [3] = '{23, 53, 0};
        int               mode_recv [3] = '{53, 23, 0};
        logic [ACT_W-1:0] lane_pick [PHASES] = '{4'd8, 4'd15, 4'd5, 4'd8, 4'd1,
                                                 4'd12, 4'd7, 4'd8, 4'd2};
        logic [GROUP_W-1:0] grp;
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = mode_send[p / 3];
            recv_idle_pct = mode_recv[p / 3];
            grp = (p == 1) ? 8'hFF : (p == 2) ? 8'h00 : GROUP_W'($urandom);
            apply_config(lane_pick[p], grp);
            run_flick_traffic(RANDOM_ITEMS / PHASES);
        end
    endtask

    // main sequence
    initial
    begin
        rst_n               = 1'b0;
        scan_bus.valid      = 1'b0;
        scan_bus.func       = FUNC_SCAN;
        scan_bus.pin_levels = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_ACTIVE_SWITCHES;
        cfg_bus.wdata       = '0;
        for (int i = 0; i < LANE_LIMIT; i++)
            lane_rec[i] = '0;
        active_cfg    = ACT_RESET;
        group_cfg     = GROUP_RESET;
        cur_levels    = '0;
        mismatches    = 0;
        send_idle_pct = 23;
        recv_idle_pct = 53;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_quick_on();
        test_fast_flicks();
        test_timeout();
        test_lane_count();
        test_random_traffic();

        drain_events();
        if (mismatches == 0 && pending_events.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sfc_pkg.sv
sv/sfc_if.sv
sv/sfc_lane.sv
sv/sfc_merge.sv
sv/switch_flick_counter_core.sv
tb/sv/testbench.sv
